[rtl/core/dspk_pkg.sv]
// Package with shared types, codes and constants of the digit string nibble packer.
`default_nettype none

package dspk_pkg;

    // Packing modes held in the mode register.
    localparam logic [1:0] MODE_BCD_RIGHT = 2'd0;
    localparam logic [1:0] MODE_BCD_LEFT  = 2'd1;
    localparam logic [1:0] MODE_HEX       = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_PACK_MODE   = 1'b0;
    localparam logic CFG_FILL_WITH_F = 1'b1;

    // Field widths.
    localparam int CHAR_W = 8;
    localparam int LEN_W  = 8;
    localparam int NIB_W  = 4;
    localparam int CFG_W  = 2;

    // Longest string the length field may announce.
    localparam int MAX_STRING_LENGTH = 255;

    // Track 2 length window in which a separator character becomes nibble D.
    localparam logic [LEN_W-1:0] TRACK2_LEN_MIN = 8'd18;
    localparam logic [LEN_W-1:0] TRACK2_LEN_MAX = 8'd37;

    // Characters and nibbles used by the decoder.
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_EQUAL = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_UP_D  = 8'h44;

    localparam logic [NIB_W-1:0] NIB_SEPARATOR = 4'hD;
    localparam logic [NIB_W-1:0] NIB_FILL_F    = 4'hF;
    localparam logic [NIB_W-1:0] NIB_FILL_ZERO = 4'h0;
    // Letters A..F and a..f carry 1..6 in their low nibble.
    localparam logic [NIB_W-1:0] NIB_LETTER_OFS = 4'd9;

    // Decoded character.
    typedef struct packed {
        logic [NIB_W-1:0] nibble;
        logic             bad;
        logic             separator;
    } t_decode;

    // Result of one character, with a flag for whether a result exists.
    typedef struct packed {
        logic             present;
        logic [CHAR_W-1:0] packed_byte;
        logic             byte_valid;
        logic             bad_char;
        logic             last_out;
    } t_result;

endpackage

`default_nettype wire

[rtl/core/dspk_char_decode.sv]
// Character to nibble decoder with track 2 separator detection.
`default_nettype none

module dspk_char_decode (
    input  wire logic [dspk_pkg::CHAR_W-1:0] i_char,
    input  wire logic [dspk_pkg::LEN_W-1:0]  i_len,
    input  wire logic                        i_hex_mode,
    input  wire logic                        i_sep_seen,
    output dspk_pkg::t_decode                o_dec
);

    logic is_digit;
    logic is_upper;
    logic is_lower;
    logic is_sep_char;
    logic in_track2;

    // Character classes.
    assign is_digit    = (i_char >= dspk_pkg::CH_ZERO) && (i_char <= dspk_pkg::CH_NINE);
    assign is_upper    = (i_char >= dspk_pkg::CH_UP_A) && (i_char <= dspk_pkg::CH_UP_F);
    assign is_lower    = (i_char >= dspk_pkg::CH_LO_A) && (i_char <= dspk_pkg::CH_LO_F);
    assign is_sep_char = (i_char == dspk_pkg::CH_CARET) || (i_char == dspk_pkg::CH_EQUAL) ||
                         (i_char == dspk_pkg::CH_UP_D);
    assign in_track2   = (i_len >= dspk_pkg::TRACK2_LEN_MIN) &&
                         (i_len <= dspk_pkg::TRACK2_LEN_MAX);

    // The separator takes priority over the digit and letter decode.
    always_comb begin
        o_dec.nibble    = dspk_pkg::NIB_FILL_ZERO;
        o_dec.bad       = 1'b0;
        o_dec.separator = 1'b0;
        if (!i_hex_mode && in_track2 && !i_sep_seen && is_sep_char) begin
            o_dec.nibble    = dspk_pkg::NIB_SEPARATOR;
            o_dec.separator = 1'b1;
        end else if (is_digit) begin
            o_dec.nibble = i_char[dspk_pkg::NIB_W-1:0];
        end else if (i_hex_mode && (is_upper || is_lower)) begin
            o_dec.nibble = i_char[dspk_pkg::NIB_W-1:0] + dspk_pkg::NIB_LETTER_OFS;
        end else begin
            o_dec.bad = 1'b1;
        end
    end

endmodule

`default_nettype wire

[rtl/core/dspk_pack_state.sv]
// String state and nibble pairing logic for one character per cycle while i_fire is high.
`default_nettype none

module dspk_pack_state (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_fire,
    input  wire logic [dspk_pkg::CHAR_W-1:0] i_char,
    input  wire logic [dspk_pkg::LEN_W-1:0]  i_len,
    input  wire logic [dspk_pkg::CFG_W-1:0]  i_pack_mode,
    input  wire logic                        i_fill_with_f,
    output dspk_pkg::t_result                o_res
);

    logic [dspk_pkg::NIB_W-1:0] r_held, n_held;
    logic [dspk_pkg::LEN_W-1:0] r_pos, n_pos;
    logic                       r_sep, n_sep;
    logic                       r_abort, n_abort;

    logic                       hex_mode;
    logic                       left_just;
    logic [dspk_pkg::NIB_W-1:0] fill;
    logic                       last;
    logic                       right_fill;
    logic                       is_low;
    logic [dspk_pkg::NIB_W-1:0] held_eff;
    dspk_pkg::t_decode          dec;

    assign hex_mode   = i_pack_mode[1];
    assign left_just  = (i_pack_mode == dspk_pkg::MODE_BCD_LEFT);
    assign fill       = i_fill_with_f ? dspk_pkg::NIB_FILL_F : dspk_pkg::NIB_FILL_ZERO;
    assign last       = ({1'b0, r_pos} + 9'd1) >= {1'b0, i_len};
    assign right_fill = i_len[0] && !left_just;
    // With a leading fill nibble, even positions carry low nibbles.
    assign is_low     = right_fill ? !r_pos[0] : r_pos[0];
    assign held_eff   = (right_fill && (r_pos == '0)) ? fill : r_held;

    dspk_char_decode u_decode (
        .i_char     (i_char),
        .i_len      (i_len),
        .i_hex_mode (hex_mode),
        .i_sep_seen (r_sep),
        .o_dec      (dec)
    );

    // Result and next state for the character in the input register.
    always_comb begin
        o_res   = '0;
        n_held  = r_held;
        n_pos   = r_pos;
        n_sep   = r_sep;
        n_abort = r_abort;
        if (i_len == '0) begin
            // A zero length character is ignored.
        end else if (r_abort) begin
            // Characters after an error are dropped until the string ends.
            n_pos = r_pos + 8'd1;
        end else begin
            n_held = held_eff;
            n_sep  = r_sep | dec.separator;
            n_pos  = r_pos + 8'd1;
            if (dec.bad) begin
                o_res.present  = 1'b1;
                o_res.bad_char = 1'b1;
                o_res.last_out = 1'b1;
                if (is_low) begin
                    o_res.packed_byte = {held_eff, dspk_pkg::NIB_FILL_ZERO};
                    o_res.byte_valid  = 1'b1;
                end
                n_abort = 1'b1;
            end else if (is_low) begin
                o_res.present     = 1'b1;
                o_res.packed_byte = {held_eff, dec.nibble};
                o_res.byte_valid  = 1'b1;
                o_res.last_out    = last;
            end else if (last) begin
                // String ends on a high nibble: fill goes into the low half.
                o_res.present     = 1'b1;
                o_res.packed_byte = {dec.nibble, fill};
                o_res.byte_valid  = 1'b1;
                o_res.last_out    = 1'b1;
            end else begin
                n_held = dec.nibble;
            end
        end
        // The final character of a string clears the state for the next one.
        if ((i_len != '0) && last) begin
            n_held  = '0;
            n_pos   = '0;
            n_sep   = 1'b0;
            n_abort = 1'b0;
        end
    end

    // State registers advance once per consumed character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_pos   <= '0;
            r_sep   <= 1'b0;
            r_abort <= 1'b0;
        end else if (i_fire) begin
            r_held  <= n_held;
            r_pos   <= n_pos;
            r_sep   <= n_sep;
            r_abort <= n_abort;
        end
    end

endmodule

`default_nettype wire

[rtl/core/digit_string_nibble_packer_top.sv]
// Top level of the digit string nibble packer: registers, handshakes and checks.
`default_nettype none

//  Channel | Direction | Handshake         | Payload
//  --------+-----------+-------------------+----------------------------------------------
//  input   | in        | i_valid / o_stall | i_char_in, i_string_length
//  output  | out       | o_valid / i_stall | o_packed_byte, o_byte_valid, o_bad_char,
//          |           |                   | o_last_out
//  config  | in        | i_cfg_wr_en       | i_cfg_index, i_cfg_data
//
//  One character per cycle while no result meets a stalled output: an accepted
//  character is held in the input register, where the decode and pairing logic
//  runs, and its result, if it makes one, is registered in the output register.
//  Synchronous active-low reset clears the string state, the mode registers and
//  both valid flags. A stall on the output holds the output register; the input
//  register keeps moving while its character makes no result.

module digit_string_nibble_packer_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [dspk_pkg::CHAR_W-1:0] i_char_in,
    input  wire logic [dspk_pkg::LEN_W-1:0]  i_string_length,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [dspk_pkg::CHAR_W-1:0]      o_packed_byte,
    output logic                             o_byte_valid,
    output logic                             o_bad_char,
    output logic                             o_last_out,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic                        i_cfg_index,
    input  wire logic [dspk_pkg::CFG_W-1:0]  i_cfg_data
);

    logic [dspk_pkg::CFG_W-1:0]  r_pack_mode;
    logic                        r_fill_with_f;
    logic                        r_in_valid, n_in_valid;
    logic [dspk_pkg::CHAR_W-1:0] r_in_char;
    logic [dspk_pkg::LEN_W-1:0]  r_in_len;
    logic                        r_out_valid, n_out_valid;
    logic [dspk_pkg::CHAR_W-1:0] r_out_byte;
    logic                        r_out_byte_valid;
    logic                        r_out_bad;
    logic                        r_out_last;

    dspk_pkg::t_result res;
    logic              out_ready;
    logic              s1_fire;
    logic              in_accept;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pack_mode   <= dspk_pkg::MODE_BCD_RIGHT;
            r_fill_with_f <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                dspk_pkg::CFG_PACK_MODE:   r_pack_mode   <= i_cfg_data;
                dspk_pkg::CFG_FILL_WITH_F: r_fill_with_f <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    dspk_pack_state u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (s1_fire),
        .i_char        (r_in_char),
        .i_len         (r_in_len),
        .i_pack_mode   (r_pack_mode),
        .i_fill_with_f (r_fill_with_f),
        .o_res         (res)
    );

    // Flow control between input register and output register.
    assign out_ready   = !r_out_valid || !i_stall;
    assign s1_fire     = r_in_valid && (!res.present || out_ready);
    assign o_stall     = r_in_valid && !s1_fire;
    assign in_accept   = i_valid && !o_stall;
    assign n_in_valid  = in_accept || (r_in_valid && !s1_fire);
    assign n_out_valid = (s1_fire && res.present) || (r_out_valid && i_stall);

    // Input register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_char <= i_char_in;
            r_in_len  <= i_string_length;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (s1_fire && res.present) begin
            r_out_byte       <= res.packed_byte;
            r_out_byte_valid <= res.byte_valid;
            r_out_bad        <= res.bad_char;
            r_out_last       <= res.last_out;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_packed_byte = r_out_byte;
    assign o_byte_valid  = r_out_byte_valid;
    assign o_bad_char    = r_out_bad;
    assign o_last_out    = r_out_last;

`ifndef SYNTH
    // An error transaction always closes the string.
    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_char) |-> o_last_out)
        else $error("error result without last flag");

    // Only an error on a high nibble produces an invalid byte, and it is zero.
    a_invalid_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_byte_valid) |-> (o_bad_char && (o_packed_byte == '0)))
        else $error("invalid byte outside a high nibble error");

    // A held character in the input register is not overwritten.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !s1_fire) |=> (r_in_valid && $stable(r_in_char) && $stable(r_in_len)))
        else $error("input register lost a pending character");
`endif

endmodule

`default_nettype wire
